[src/swfc_pkg.sv]
// swfc_pkg: widths, constants, codes and types shared by the frame checker
// depends on: nothing
`timescale 1ns / 1ps

package swfc_pkg;

   localparam int ByteW   = 8;
   localparam int WordW   = 16;
   localparam int PosW    = 4;
   localparam int BadW    = 2;
   localparam int TempW   = 15;
   localparam int HumW    = 14;

   // byte position codes
   localparam logic [PosW-1:0] PosIdle     = 4'd15;
   localparam logic [PosW-1:0] PosFirst    = 4'd0;
   localparam logic [PosW-1:0] PosLastStat = 4'd2;
   localparam logic [PosW-1:0] PosLastMeas = 4'd8;

   // frame kind codes
   localparam logic KindStatus = 1'b0;
   localparam logic KindMeas   = 1'b1;

   // crc-8, poly 0x31, msb first
   localparam logic [ByteW-1:0] CrcPoly = 8'h31;
   localparam logic [ByteW-1:0] CrcInit = 8'hFF;

   localparam logic [WordW-1:0] StatusMask = 16'h07FF;

   // temp = -4500 + floor(17500 * raw / 65536), hum = floor(10000 * raw / 65536)
   localparam logic [14:0] TempScale  = 15'd17500;
   localparam logic [15:0] TempOffset = 16'd4500;
   localparam logic [13:0] HumScale   = 14'd10000;

   localparam logic [BadW-1:0] WordFirst = 2'd0;

   // place of a byte inside its word
   typedef enum logic [2:0] {
      PH_HIGH = 3'b001,
      PH_LOW  = 3'b010,
      PH_CRC  = 3'b100
   } phase_type;

endpackage

[src/swfc_if.sv]
// swfc_req_if / swfc_rsp_if: valid/ready channels for received bytes and frame results
// depends on: swfc_pkg
`timescale 1ns / 1ps

interface swfc_req_if import swfc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;
   logic             frame_start;
   logic             req_type;

   modport source (output valid, output rx_byte, output frame_start, output req_type,
                   input ready);
   modport sink   (input valid, input rx_byte, input frame_start, input req_type,
                   output ready);
endinterface

interface swfc_rsp_if import swfc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    result_kind;
   logic                    crc_ok;
   logic [BadW-1:0]         bad_word;
   logic                    ready_flag;
   logic [WordW-1:0]        status_raw;
   logic [WordW-1:0]        co2_ppm;
   logic signed [TempW-1:0] temp_centi;
   logic [HumW-1:0]         humidity_centi;

   modport source (output valid, output result_kind, output crc_ok, output bad_word,
                   output ready_flag, output status_raw, output co2_ppm,
                   output temp_centi, output humidity_centi, input ready);
   modport sink   (input valid, input result_kind, input crc_ok, input bad_word,
                   input ready_flag, input status_raw, input co2_ppm,
                   input temp_centi, input humidity_centi, output ready);
endinterface

[src/sensor_word_frame_checker.sv]
// sensor_word_frame_checker: crc check and decode of status and measurement frames
// timing: the last byte of a frame passes the input register and then the result register before its result is valid
// flow: a new byte can enter while the last is processed; input stalls only while a result waits unaccepted
// reset: synchronous, active high; clears channel valids and returns to no frame
// depends on: swfc_pkg, swfc_req_if, swfc_rsp_if, swfc_crc8, swfc_scale
`timescale 1ns / 1ps

module sensor_word_frame_checker import swfc_pkg::*; (
   input logic         clock,
   input logic         reset,
   swfc_req_if.sink    req_ch,
   swfc_rsp_if.source  rsp_ch
);

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [ByteW-1:0] in_byte_ff;
   logic             in_start_ff;
   logic             in_type_ff;

   // frame state
   logic [PosW-1:0]  pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [BadW-1:0]  word_ff, word_in;
   logic             kind_ff, kind_in;
   logic [ByteW-1:0] crc_ff, crc_in;
   logic [ByteW-1:0] high_ff, high_in;
   logic             err_ff, err_in;
   logic [BadW-1:0]  bad_ff, bad_in;

   // word store, written before being read within a frame
   logic [WordW-1:0]        word0_ff;
   logic signed [TempW-1:0] temp_ff;
   logic [HumW-1:0]         hum_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    kind_out_ff;
   logic                    ok_out_ff;
   logic [BadW-1:0]         bad_out_ff;
   logic                    rdy_out_ff;
   logic [WordW-1:0]        stat_out_ff;
   logic [WordW-1:0]        co2_out_ff;
   logic signed [TempW-1:0] temp_out_ff;
   logic [HumW-1:0]         hum_out_ff;

   logic                    advance;
   logic                    active;
   logic                    res_load;
   logic [PosW-1:0]         pos_cur;
   phase_type               phase_cur;
   logic [BadW-1:0]         word_cur;
   logic [ByteW-1:0]        crc_cur;
   logic                    err_cur;
   logic [BadW-1:0]         bad_cur;
   logic [PosW-1:0]         pos_last;
   logic [ByteW-1:0]        crc_seed;
   logic [ByteW-1:0]        crc_step;
   logic [WordW-1:0]        new_word;
   logic signed [TempW-1:0] temp_new;
   logic [HumW-1:0]         hum_new;
   logic                    store0, store1, store2;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_ch.ready) begin
         in_byte_ff  <= req_ch.rx_byte;
         in_start_ff <= req_ch.frame_start;
         in_type_ff  <= req_ch.req_type;
      end
   end

   // frame start overrides the held context
   assign active    = in_start_ff || (pos_ff != PosIdle);
   assign pos_cur   = in_start_ff ? PosFirst : pos_ff;
   assign phase_cur = in_start_ff ? PH_HIGH : phase_ff;
   assign word_cur  = in_start_ff ? WordFirst : word_ff;
   assign kind_in   = in_start_ff ? in_type_ff : kind_ff;
   assign crc_cur   = in_start_ff ? CrcInit : crc_ff;
   assign err_cur   = in_start_ff ? 1'b0 : err_ff;
   assign bad_cur   = in_start_ff ? WordFirst : bad_ff;
   assign pos_last  = (kind_in == KindMeas) ? PosLastMeas : PosLastStat;
   assign crc_seed  = (phase_cur == PH_HIGH) ? CrcInit : crc_cur;
   assign new_word  = {high_ff, in_byte_ff};

   swfc_crc8 u_crc (
      .crc_in  (crc_seed),
      .data_in (in_byte_ff),
      .crc_out (crc_step)
   );

   swfc_scale u_scale (
      .raw_word       (new_word),
      .temp_centi     (temp_new),
      .humidity_centi (hum_new)
   );

   always_comb begin
      high_in  = high_ff;
      crc_in   = crc_step;
      err_in   = err_cur;
      bad_in   = bad_cur;
      store0   = 1'b0;
      store1   = 1'b0;
      store2   = 1'b0;
      phase_in = phase_cur;
      word_in  = word_cur;
      unique case (phase_cur)
         PH_HIGH: begin
            high_in  = in_byte_ff;
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            store0   = (word_cur == 2'd0);
            store1   = (word_cur == 2'd1);
            store2   = (word_cur == 2'd2);
            phase_in = PH_CRC;
         end
         PH_CRC: begin
            crc_in = CrcInit;
            if ((crc_cur != in_byte_ff) && !err_cur) begin
               err_in = 1'b1;
               bad_in = word_cur;
            end
            phase_in = PH_HIGH;
            word_in  = word_cur + 2'd1;
         end
         default: begin
            phase_in = PH_HIGH;
         end
      endcase
   end

   assign res_load = advance && active && (pos_cur == pos_last);
   assign pos_in   = (pos_cur == pos_last) ? PosIdle : pos_cur + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= PosIdle;
         phase_ff <= PH_HIGH;
         word_ff  <= WordFirst;
         kind_ff  <= KindStatus;
         crc_ff   <= CrcInit;
         high_ff  <= '0;
         err_ff   <= 1'b0;
         bad_ff   <= WordFirst;
      end else if (advance && active) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         word_ff  <= word_in;
         kind_ff  <= kind_in;
         crc_ff   <= crc_in;
         high_ff  <= high_in;
         err_ff   <= err_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && active && store0) begin
         word0_ff <= new_word;
      end
      if (advance && active && store1) begin
         temp_ff <= temp_new;
      end
      if (advance && active && store2) begin
         hum_ff <= hum_new;
      end
   end

   assign rsp_valid_in = res_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_load) begin
         kind_out_ff <= kind_in;
         ok_out_ff   <= !err_in;
         bad_out_ff  <= err_in ? bad_in : WordFirst;
         if (kind_in == KindStatus) begin
            rdy_out_ff  <= !err_in && ((word0_ff & StatusMask) != '0);
            stat_out_ff <= word0_ff;
            co2_out_ff  <= '0;
            temp_out_ff <= '0;
            hum_out_ff  <= '0;
         end else begin
            rdy_out_ff  <= 1'b0;
            stat_out_ff <= '0;
            co2_out_ff  <= word0_ff;
            temp_out_ff <= temp_ff;
            hum_out_ff  <= hum_ff;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = kind_out_ff;
   assign rsp_ch.crc_ok         = ok_out_ff;
   assign rsp_ch.bad_word       = bad_out_ff;
   assign rsp_ch.ready_flag     = rdy_out_ff;
   assign rsp_ch.status_raw     = stat_out_ff;
   assign rsp_ch.co2_ppm        = co2_out_ff;
   assign rsp_ch.temp_centi     = temp_out_ff;
   assign rsp_ch.humidity_centi = hum_out_ff;

`ifndef NO_ASSERTIONS
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      res_load |=> (pos_ff == PosIdle))
      else $error("frame still active after its result");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == PosIdle) || (pos_ff <= PosLastMeas))
      else $error("byte position out of range");

   a_status_short: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != PosIdle) && (kind_ff == KindStatus) |-> (pos_ff <= PosLastStat))
      else $error("status frame ran past its last word");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !advance)
      else $error("frame advanced while a result is waiting");

   a_error_kept: assert property (@(posedge clock) disable iff (reset)
      advance && active && !in_start_ff && err_ff |=> err_ff && $stable(bad_ff))
      else $error("first bad word lost inside a frame");
`endif

endmodule

[src/swfc_crc8.sv]
// swfc_crc8: one byte step of crc-8 (poly 0x31, msb first), unrolled over 8 bits
// depends on: swfc_pkg
`timescale 1ns / 1ps

module swfc_crc8 import swfc_pkg::*; (
   input  logic [ByteW-1:0] crc_in,
   input  logic [ByteW-1:0] data_in,
   output logic [ByteW-1:0] crc_out
);

   always_comb begin
      logic [ByteW-1:0] c;
      c = crc_in ^ data_in;
      for (int i = 0; i < ByteW; i++) begin
         if (c[ByteW-1]) begin
            c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[ByteW-2:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule

[src/swfc_scale.sv]
// swfc_scale: converts a raw word to temperature and humidity in hundredths
// depends on: swfc_pkg
`timescale 1ns / 1ps

module swfc_scale import swfc_pkg::*; (
   input  logic [WordW-1:0]        raw_word,
   output logic signed [TempW-1:0] temp_centi,
   output logic [HumW-1:0]         humidity_centi
);

   logic [30:0] temp_prod;
   logic [29:0] hum_prod;
   logic [15:0] temp_wide;

   assign temp_prod      = 31'(raw_word) * 31'(TempScale);
   assign hum_prod       = 30'(raw_word) * 30'(HumScale);
   assign temp_wide      = {1'b0, temp_prod[30:16]} - TempOffset;
   assign temp_centi     = signed'(temp_wide[TempW-1:0]);
   assign humidity_centi = hum_prod[29:16];

endmodule

[tb/sv/sensor_word_frame_checker_test.sv]
// sensor_word_frame_checker_test: drives status and measurement frames byte by byte with
// random gaps and output stalls, predicts each frame result and checks it field by field
// depends on: swfc_pkg, swfc_req_if, swfc_rsp_if, sensor_word_frame_checker
`timescale 1ns / 1ps

module sensor_word_frame_checker_test;
   import swfc_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 12;
   localparam int RandomWords = 1350;
   localparam int SteadyWords = 250;
   localparam int HoldCycles  = 80;

   typedef struct packed {
      logic                    kind;
      logic                    crc_ok;
      logic [BadW-1:0]         bad_word;
      logic                    ready_flag;
      logic [WordW-1:0]        status_raw;
      logic [WordW-1:0]        co2;
      logic signed [TempW-1:0] temp;
      logic [HumW-1:0]         hum;
   } frame_result_type;

   logic clock;
   logic reset;

   swfc_req_if req_if ();
   swfc_rsp_if rsp_if ();

   sensor_word_frame_checker u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // frame tracking state
   logic [PosW-1:0]  frame_pos  = PosIdle;
   logic             frame_kind = KindStatus;
   logic [ByteW-1:0] run_crc    = CrcInit;
   logic [ByteW-1:0] high_byte  = '0;
   logic             crc_err    = 1'b0;
   logic [BadW-1:0]  first_bad  = WordFirst;
   logic [BadW-1:0]  word_idx   = WordFirst;
   phase_type        phase      = PH_HIGH;
   logic [WordW-1:0] word_val [3];

   frame_result_type pending_results [$];

   bit          sender_gaps   = 1'b0;
   bit          receiver_gaps = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [ByteW-1:0] crc8_next(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
      logic [ByteW-1:0] c;
      c = crc ^ b;
      for (int i = 0; i < ByteW; i++)
         c = c[ByteW-1] ? ((c << 1) ^ CrcPoly) : (c << 1);
      return c;
   endfunction

   function automatic logic [WordW-1:0] pick_word();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return {5'($urandom), 11'd0};
         default: return 16'($urandom);
      endcase
   endfunction

   // follow one accepted byte and queue the frame result when a frame completes
   task automatic follow_byte(input logic [ByteW-1:0] b, input logic fs, input logic rt);
      frame_result_type r;
      logic [31:0]      t;
      logic [PosW-1:0]  last;
      if (fs) begin
         frame_pos  = PosFirst;
         frame_kind = rt;
         run_crc    = CrcInit;
         crc_err    = 1'b0;
         first_bad  = WordFirst;
         word_idx   = WordFirst;
         phase      = PH_HIGH;
      end else if (frame_pos == PosIdle) begin
         return;
      end
      unique case (phase)
         PH_HIGH: begin
            high_byte = b;
            run_crc   = crc8_next(CrcInit, b);
            phase     = PH_LOW;
         end
         PH_LOW: begin
            run_crc            = crc8_next(run_crc, b);
            word_val[word_idx] = {high_byte, b};
            phase              = PH_CRC;
         end
         default: begin
            if (run_crc != b && !crc_err) begin
               crc_err   = 1'b1;
               first_bad = word_idx;
            end
            run_crc = CrcInit;
            word_idx++;
            phase = PH_HIGH;
         end
      endcase
      last = (frame_kind == KindMeas) ? PosLastMeas : PosLastStat;
      if (frame_pos != last) begin
         frame_pos++;
         return;
      end
      frame_pos  = PosIdle;
      r          = '0;
      r.kind     = frame_kind;
      r.crc_ok   = !crc_err;
      r.bad_word = crc_err ? first_bad : WordFirst;
      if (frame_kind == KindStatus) begin
         r.ready_flag = !crc_err && ((word_val[0] & StatusMask) != '0);
         r.status_raw = word_val[0];
      end else begin
         r.co2  = word_val[0];
         t      = (32'(TempScale) * word_val[1]) >> 16;
         r.temp = 15'(t - 32'(TempOffset));
         r.hum  = 14'((32'(HumScale) * word_val[2]) >> 16);
      end
      pending_results.push_back(r);
   endtask

   task automatic send_byte(input logic [ByteW-1:0] b, input logic fs, input logic rt);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.rx_byte     <= b;
      req_if.frame_start <= fs;
      req_if.req_type    <= rt;
      do @(posedge clock); while (!req_if.ready);
      follow_byte(b, fs, rt);
   endtask

   // sends the first cut bytes of a frame; bad marks words whose crc byte is corrupted
   task automatic send_frame(input logic kind, input logic [WordW-1:0] w0,
                             input logic [WordW-1:0] w1, input logic [WordW-1:0] w2,
                             input logic [2:0] bad, input int cut);
      logic [2:0][WordW-1:0] w;
      logic [ByteW-1:0]      bytes [9];
      logic [ByteW-1:0]      c;
      int                    len;
      w   = {w2, w1, w0};
      len = (kind == KindMeas) ? int'(PosLastMeas) + 1 : int'(PosLastStat) + 1;
      for (int i = 0; i < 3; i++) begin
         c = crc8_next(crc8_next(CrcInit, w[i][15:8]), w[i][7:0]);
         if (bad[i])
            c ^= 8'($urandom_range(1, 255));
         bytes[3*i]   = w[i][15:8];
         bytes[3*i+1] = w[i][7:0];
         bytes[3*i+2] = c;
      end
      for (int j = 0; j < len && j < cut; j++)
         send_byte(bytes[j], j == 0, (j == 0) ? kind : 1'($urandom));
   endtask

   task automatic run_random_frames(input int target_words, input bit gaps);
      int          sent;
      int          len;
      int          cut;
      logic        kind;
      logic [2:0]  bad;
      sent = 0;
      while (sent < target_words) begin
         sender_gaps   = gaps && ($urandom_range(0, 4) != 0);
         receiver_gaps = gaps && ($urandom_range(0, 4) != 0);
         // stray byte between frames
         if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom), 1'b0, 1'($urandom));
         kind = 1'($urandom);
         bad  = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000;
         len  = (kind == KindMeas) ? int'(PosLastMeas) + 1 : int'(PosLastStat) + 1;
         cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
         send_frame(kind, pick_word(), pick_word(), pick_word(), bad, cut);
         sent += cut;
      end
   endtask

   task automatic test_stray_bytes();
      send_byte(8'h00, 1'b0, KindStatus);
      send_byte(8'hFF, 1'b0, KindMeas);
   endtask

   task automatic test_status_frames();
      send_frame(KindStatus, 16'h07FF, '0, '0, 3'b000, 3);
      send_frame(KindStatus, 16'hF800, '0, '0, 3'b001, 3);
   endtask

   task automatic test_measurement_extremes();
      send_frame(KindMeas, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 9);
   endtask

   task automatic test_restart_mid_frame();
      send_frame(KindMeas, 16'h0000, 16'h0000, 16'h0000, 3'b010, 4);
      send_frame(KindStatus, 16'h0001, '0, '0, 3'b000, 3);
   endtask

   task automatic test_random_traffic();
      run_random_frames(RandomWords, 1'b1);
   endtask

   task automatic test_output_backpressure();
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      hold_left     = HoldCycles;
      repeat (10)
         send_frame(KindStatus, pick_word(), '0, '0, 3'b000, 3);
   endtask

   task automatic test_steady_stream();
      run_random_frames(SteadyWords, 1'b0);
   endtask

   // receiver side: random stalls plus one long hold-off
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            while (hold_left != 0) begin
               @(posedge clock);
               hold_left--;
            end
         end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no frame pending");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", want.kind, rsp_if.result_kind);
            check_field("crc_ok", want.crc_ok, rsp_if.crc_ok);
            check_field("bad_word", want.bad_word, rsp_if.bad_word);
            check_field("ready_flag", want.ready_flag, rsp_if.ready_flag);
            check_field("status_raw", want.status_raw, rsp_if.status_raw);
            check_field("co2_ppm", want.co2, rsp_if.co2_ppm);
            check_field("temp_centi", int'(want.temp), int'(rsp_if.temp_centi));
            check_field("humidity_centi", want.hum, rsp_if.humidity_centi);
         end
      end
   end

   initial begin
      req_if.valid       <= 1'b0;
      req_if.rx_byte     <= '0;
      req_if.frame_start <= 1'b0;
      req_if.req_type    <= 1'b0;
      reset              <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_stray_bytes();
      test_status_frames();
      test_measurement_extremes();
      test_restart_mid_frame();
      test_random_traffic();
      test_output_backpressure();
      test_steady_stream();

      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
